### sv/isee_pkg.sv
package isee_pkg;

  localparam int MAX_VERTICES = 4096;
  localparam int MAX_EDGES    = 16384;
  localparam int MAX_DEGREE   = 64;

  localparam int OpW    = 3;
  localparam int IdxW   = 15;
  localparam int VertW  = $clog2(MAX_VERTICES);
  localparam int RowAW  = $clog2(MAX_VERTICES + 1);
  localparam int NbrAW  = $clog2(MAX_EDGES);
  localparam int CntW   = $clog2(MAX_DEGREE + 1);
  localparam int ClrW   = VertW;

  typedef enum logic [OpW-1:0] {
    OP_LOAD_ROW = 3'd0,
    OP_LOAD_NBR = 3'd1,
    OP_MARK     = 3'd2,
    OP_INDUCE   = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACK,
    ST_ROW0,
    ST_ROW1,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             we;
    logic [RowAW-1:0] waddr;
    logic [IdxW-1:0]  wdata;
    logic             re;
    logic [RowAW-1:0] raddr;
  } row_req_t;

  typedef struct packed {
    logic             we;
    logic [NbrAW-1:0] waddr;
    logic [VertW-1:0] wdata;
    logic             re;
    logic [NbrAW-1:0] raddr;
  } nbr_req_t;

  typedef struct packed {
    logic             we;
    logic [VertW-1:0] waddr;
    logic             wdata;
    logic             re;
    logic [VertW-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic [VertW-1:0] source_vertex;
    logic [VertW-1:0] dest_vertex;
    logic             edge_valid;
    logic             last_of_run;
    logic             status;
  } out_word_t;

endpackage

### sv/induced_subgraph_edge_extractor.sv
// Induced subgraph edge extractor over a graph held in compressed sparse row form.
// Input channel (in_valid / in_stall) carries one word per operation: load a row
// start entry, load a neighbor entry, mark a vertex as sampled, induce a vertex, or
// clear all marks. Result channel (out_valid / out_stall) returns words with
// source/dest vertex, edge_valid, last_of_run and status.
// Loads and marks pass through an acknowledge state that registers one acknowledge
// word once the output is free, then return to idle to take the next input word.
// An induce reads two row start entries, then walks the neighbor list one entry per
// cycle, unless a stalled output holds the walk, through a read pipeline (neighbor
// memory, then sampled bitmap memory). Every marked neighbor gives one edge word; a
// run with none gives one empty word. A run holds at most 64 edges: when one more
// marked neighbor exists, the run is cut, flagged by status on its last word. Only
// one input word is worked on at a time; in_stall is high meanwhile.
// Reset clears the sampled bitmap one entry per cycle with in_stall high.
// A clear-marks operation runs the same pass, then acknowledges.
// A stalled output holds its word; the walk freezes once the next edge word is ready.
module induced_subgraph_edge_extractor import isee_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OpW-1:0]   in_operation,
  input  logic [IdxW-1:0]  in_table_index,
  input  logic [IdxW-1:0]  in_table_value,
  input  logic [VertW-1:0] in_vertex_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VertW-1:0] out_source_vertex,
  output logic [VertW-1:0] out_dest_vertex,
  output logic             out_edge_valid,
  output logic             out_last_of_run,
  output logic             out_status
);

  row_req_t         row_req;
  nbr_req_t         nbr_req;
  map_req_t         map_req;
  logic [IdxW-1:0]  row_rdata;
  logic [VertW-1:0] nbr_rdata;
  logic             map_rdata;
  out_word_t        out_word;

  isee_ram #(.Width(IdxW), .Depth(MAX_VERTICES + 1)) u_row_ram (
    .clk   (clk),
    .we    (row_req.we),
    .waddr (row_req.waddr),
    .wdata (row_req.wdata),
    .re    (row_req.re),
    .raddr (row_req.raddr),
    .rdata (row_rdata)
  );

  isee_ram #(.Width(VertW), .Depth(MAX_EDGES)) u_nbr_ram (
    .clk   (clk),
    .we    (nbr_req.we),
    .waddr (nbr_req.waddr),
    .wdata (nbr_req.wdata),
    .re    (nbr_req.re),
    .raddr (nbr_req.raddr),
    .rdata (nbr_rdata)
  );

  isee_ram #(.Width(1), .Depth(MAX_VERTICES)) u_map_ram (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .re    (map_req.re),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

  isee_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_vertex_id   (in_vertex_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .row_req        (row_req),
    .row_rdata      (row_rdata),
    .nbr_req        (nbr_req),
    .nbr_rdata      (nbr_rdata),
    .map_req        (map_req),
    .map_rdata      (map_rdata)
  );

  assign out_source_vertex = out_word.source_vertex;
  assign out_dest_vertex   = out_word.dest_vertex;
  assign out_edge_valid    = out_word.edge_valid;
  assign out_last_of_run   = out_word.last_of_run;
  assign out_status        = out_word.status;

endmodule

### sv/isee_ram.sv
module isee_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/isee_ctrl.sv
module isee_ctrl import isee_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OpW-1:0]   in_operation,
  input  logic [IdxW-1:0]  in_table_index,
  input  logic [IdxW-1:0]  in_table_value,
  input  logic [VertW-1:0] in_vertex_id,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  output row_req_t         row_req,
  input  logic [IdxW-1:0]  row_rdata,
  output nbr_req_t         nbr_req,
  input  logic [VertW-1:0] nbr_rdata,
  output map_req_t         map_req,
  input  logic             map_rdata
);

  state_t           state_r, state_nxt;
  logic [ClrW-1:0]  clr_idx_r, clr_idx_nxt;
  logic             clr_ack_r, clr_ack_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             out_load;
  logic             out_free;
  logic [VertW-1:0] v_r, v_nxt;
  logic [IdxW-1:0]  j_r, j_nxt;
  logic [IdxW-1:0]  stop_r, stop_nxt;
  logic             a_v_r, a_v_nxt;
  logic             b_v_r, b_v_nxt;
  logic [VertW-1:0] d_r, d_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [VertW-1:0] pend_d_r, pend_d_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             a_issue;
  logic             hit;
  logic             adv;

  assign out_free  = !out_valid_r || !out_stall;
  assign a_issue   = (j_r < stop_r) && (j_r < IdxW'(MAX_EDGES));
  assign hit       = b_v_r && map_rdata;
  assign adv       = !(hit && pend_v_r && !out_free);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      clr_ack_r   <= 1'b0;
      out_valid_r <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_ack_r   <= clr_ack_nxt;
      out_valid_r <= out_valid_nxt;
      a_v_r       <= a_v_nxt;
      b_v_r       <= b_v_nxt;
      pend_v_r    <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    v_r        <= v_nxt;
    j_r        <= j_nxt;
    stop_r     <= stop_nxt;
    d_r        <= d_nxt;
    pend_d_r   <= pend_d_nxt;
    count_r    <= count_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    clr_ack_nxt  = clr_ack_r;
    out_word_nxt = out_word_r;
    out_load     = 1'b0;
    v_nxt        = v_r;
    j_nxt        = j_r;
    stop_nxt     = stop_r;
    a_v_nxt      = 1'b0;
    b_v_nxt      = 1'b0;
    d_nxt        = d_r;
    pend_v_nxt   = pend_v_r;
    pend_d_nxt   = pend_d_r;
    count_nxt    = count_r;
    row_req      = '0;
    nbr_req      = '0;
    map_req      = '0;

    case (state_r)
      ST_CLEAR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_idx_r;
        map_req.wdata = 1'b0;
        clr_idx_nxt   = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt   = clr_ack_r ? ST_ACK : ST_IDLE;
          clr_ack_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op_t'(in_operation))
            OP_LOAD_ROW: begin
              row_req.we    = (in_table_index <= IdxW'(MAX_VERTICES));
              row_req.waddr = in_table_index[RowAW-1:0];
              row_req.wdata = in_table_value;
              state_nxt     = ST_ACK;
            end
            OP_LOAD_NBR: begin
              nbr_req.we    = (in_table_index < IdxW'(MAX_EDGES));
              nbr_req.waddr = in_table_index[NbrAW-1:0];
              nbr_req.wdata = in_table_value[VertW-1:0];
              state_nxt     = ST_ACK;
            end
            OP_MARK: begin
              map_req.we    = 1'b1;
              map_req.waddr = in_vertex_id;
              map_req.wdata = 1'b1;
              state_nxt     = ST_ACK;
            end
            OP_INDUCE: begin
              row_req.re    = 1'b1;
              row_req.raddr = RowAW'(in_vertex_id);
              v_nxt         = in_vertex_id;
              pend_v_nxt    = 1'b0;
              count_nxt     = '0;
              state_nxt     = ST_ROW0;
            end
            OP_CLEAR: begin
              clr_idx_nxt = '0;
              clr_ack_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_word_nxt = '{source_vertex: '0, dest_vertex: '0, edge_valid: 1'b0,
                           last_of_run: 1'b1, status: 1'b0};
          state_nxt    = ST_IDLE;
        end
      end
      ST_ROW0: begin
        j_nxt         = row_rdata;
        row_req.re    = 1'b1;
        row_req.raddr = RowAW'(v_r) + RowAW'(1);
        state_nxt     = ST_ROW1;
      end
      ST_ROW1: begin
        stop_nxt  = row_rdata;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        nbr_req.re    = adv && a_issue;
        nbr_req.raddr = j_r[NbrAW-1:0];
        map_req.re    = adv && a_v_r;
        map_req.raddr = nbr_rdata;
        a_v_nxt       = a_v_r;
        b_v_nxt       = b_v_r;
        if (adv) begin
          a_v_nxt = a_issue;
          b_v_nxt = a_v_r;
          d_nxt   = nbr_rdata;
          if (a_issue) begin
            j_nxt = j_r + 1'b1;
          end
        end
        if (hit && adv) begin
          if (count_r == CntW'(MAX_DEGREE)) begin
            out_load     = 1'b1;
            out_word_nxt = '{source_vertex: v_r, dest_vertex: pend_d_r, edge_valid: 1'b1,
                             last_of_run: 1'b1, status: 1'b1};
            a_v_nxt      = 1'b0;
            b_v_nxt      = 1'b0;
            pend_v_nxt   = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            if (pend_v_r) begin
              out_load     = 1'b1;
              out_word_nxt = '{source_vertex: v_r, dest_vertex: pend_d_r, edge_valid: 1'b1,
                               last_of_run: 1'b0, status: 1'b0};
            end
            pend_d_nxt = d_r;
            pend_v_nxt = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end else if (!a_issue && !a_v_r && !b_v_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_v_r) begin
            out_word_nxt = '{source_vertex: v_r, dest_vertex: pend_d_r, edge_valid: 1'b1,
                             last_of_run: 1'b1, status: 1'b0};
          end else begin
            out_word_nxt = '{source_vertex: v_r, dest_vertex: '0, edge_valid: 1'b0,
                             last_of_run: 1'b1, status: 1'b0};
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

endmodule
